/* rtl/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_alu, ffha_seq and the top level; depends on nothing.
package ffha_pkg;

    localparam int ARENA_BYTES_DEF  = 128;
    localparam int HEADER_BYTES_DEF = 8;

    // Fixed field widths of the request and result beats.
    localparam int REQ_W = 8;
    localparam int OFF_W = 7;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Header word flag positions.
    localparam int FLAG_FREE_BIT = 0;
    localparam int FLAG_LAST_BIT = 1;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_HCHECK,
        S_ABS_CHK,
        S_ABS_RD,
        S_FIT,
        S_ADV,
        S_SPLIT_A,
        S_SPLIT_B,
        S_SPLIT_C,
        S_SPLIT_D,
        S_GRANT,
        S_FREE_A,
        S_FREE_B,
        S_DONE
    } state_t;

endpackage

/* rtl/ffha_mem.sv */
// Header word store: one write port and one read port with registered data.
// Depends on nothing outside this file.
module ffha_mem #(
    parameter int WORDS = 32,
    parameter int HW    = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [HW-1:0]            wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [HW-1:0]            rdata
);

    logic [HW-1:0] mem [WORDS];
    logic [HW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ffha_alu.sv */
// Shared adder/subtractor used by the sequencer for every size and offset step.
// Depends on ffha_pkg for the operation codes.
module ffha_alu
    import ffha_pkg::*;
#(
    parameter int W = 10
) (
    input  alu_op_t        op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [W-1:0]   res,
    output logic           borrow
);

    logic [W:0] full;

    always_comb
    begin
        unique case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = '0;
        endcase
    end

    // For a subtraction the top bit is the borrow; adds never overflow here.
    assign res    = full[W-1:0];
    assign borrow = full[W];

endmodule

/* rtl/ffha_seq.sv */
// Sequencer of the allocator: walks, merges, splits and frees chunk headers,
// one header access and one pass through the shared adder per cycle.
// Depends on ffha_pkg; drives ffha_mem and ffha_alu from the top level.
module ffha_seq
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int WORDS        = ARENA_BYTES / 4,
    parameter int HW           = $clog2(ARENA_BYTES) + 1,
    parameter int CW           = ((HW > REQ_W + 1) ? HW : REQ_W + 1) + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic [REQ_W-1:0]         req_size,
    input  logic [OFF_W-1:0]         free_offset,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [OFF_W-1:0]         payload_offset,
    output logic                     granted,
    output logic                     mem_we,
    output logic [$clog2(WORDS)-1:0] mem_waddr,
    output logic [HW-1:0]            mem_wdata,
    output logic [$clog2(WORDS)-1:0] mem_raddr,
    input  logic [HW-1:0]            mem_rdata,
    output alu_op_t                  alu_op,
    output logic [CW-1:0]            alu_a,
    output logic [CW-1:0]            alu_b,
    input  logic [CW-1:0]            alu_res,
    input  logic                     alu_borrow
);

    localparam int AW    = $clog2(WORDS);
    localparam int NW    = AW + 1;
    localparam int HDR   = ((HEADER_BYTES + 3) / 4) * 4;
    localparam int SLACK = HEADER_BYTES + 4;

    localparam logic [HW-1:0] INIT_WORD = HW'(ARENA_BYTES) | HW'(3);

    state_t              state_reg, state_next;
    logic [REQ_W:0]      size_reg, size_next;
    logic [OFF_W-1:0]    foff_reg, foff_next;
    logic [HW-1:0]       pos_reg, pos_next;
    logic [HW-1:0]       h_reg, h_next;
    logic [HW-1:0]       nxt_reg, nxt_next;
    logic [CW-1:0]       diff_reg, diff_next;
    logic [CW-1:0]       tmp_reg, tmp_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NW-1:0]       m_reg, m_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [OFF_W-1:0]    res_off_reg, res_off_next;
    logic                res_ok_reg, res_ok_next;
    logic                out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]    out_off_reg, out_off_next;
    logic                out_ok_reg, out_ok_next;

    logic [HW-1:0]       h_real;
    logic [HW-1:0]       nh_real;
    logic [REQ_W:0]      rounded;
    logic [NW-1:0]       n_inc;

    assign h_real  = {h_reg[HW-1:2], 2'b00};
    assign nh_real = {mem_rdata[HW-1:2], 2'b00};
    assign n_inc   = n_reg + 1'b1;
    assign rounded = {alu_res[REQ_W:2], 2'b00};

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign payload_offset = out_off_reg;
    assign granted        = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        foff_reg    <= foff_next;
        pos_reg     <= pos_next;
        h_reg       <= h_next;
        nxt_reg     <= nxt_next;
        diff_reg    <= diff_next;
        tmp_reg     <= tmp_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        res_off_reg <= res_off_next;
        res_ok_reg  <= res_ok_next;
        out_off_reg <= out_off_next;
        out_ok_reg  <= out_ok_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        foff_next      = foff_reg;
        pos_next       = pos_reg;
        h_next         = h_reg;
        nxt_next       = nxt_reg;
        diff_next      = diff_reg;
        tmp_next       = tmp_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        clr_next       = clr_reg;
        res_off_next   = res_off_reg;
        res_ok_next    = res_ok_reg;
        out_off_next   = out_off_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? INIT_WORD : '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next  = {1'b0, req_size};
                    foff_next  = free_offset;
                    pos_next   = '0;
                    n_next     = '0;
                    state_next = (cmd == CMD_FREE) ? S_FREE_A : S_SIZE;
                end
            end

            S_SIZE:
            begin
                // Round up to a word; a zero request is served as one word.
                alu_op    = ALU_ADD;
                alu_a     = CW'(size_reg);
                alu_b     = CW'(3);
                size_next = (rounded == '0) ? (REQ_W + 1)'(4) : rounded;
                mem_raddr = '0;
                state_next = S_HCHECK;
            end

            S_HCHECK:
            begin
                if (mem_rdata == '0)
                begin
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    h_next     = mem_rdata;
                    m_next     = '0;
                    state_next = mem_rdata[FLAG_FREE_BIT] ? S_ABS_CHK : S_FIT;
                end
            end

            S_ABS_CHK:
            begin
                alu_op = ALU_ADD;
                alu_a  = CW'(pos_reg);
                alu_b  = CW'(h_real);
                if (h_reg[FLAG_LAST_BIT] || (h_real == '0) ||
                    (alu_res >= CW'(ARENA_BYTES)) || (m_reg == NW'(WORDS)))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW+1:2];
                    mem_wdata  = h_reg;
                    state_next = S_FIT;
                end
                else
                begin
                    mem_raddr  = alu_res[AW+1:2];
                    nxt_next   = alu_res[HW-1:0];
                    state_next = S_ABS_RD;
                end
            end

            S_ABS_RD:
            begin
                alu_op = ALU_ADD;
                alu_a  = CW'(h_real);
                alu_b  = CW'(nh_real);
                if ((mem_rdata == '0) || !mem_rdata[FLAG_FREE_BIT])
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW+1:2];
                    mem_wdata  = h_reg;
                    state_next = S_FIT;
                end
                else
                begin
                    // The merged chunk inherits the follower's last flag.
                    h_next     = {alu_res[HW-1:2], mem_rdata[FLAG_LAST_BIT],
                                  h_reg[FLAG_FREE_BIT]};
                    mem_we     = 1'b1;
                    mem_waddr  = nxt_reg[AW+1:2];
                    mem_wdata  = '0;
                    m_next     = m_reg + 1'b1;
                    state_next = S_ABS_CHK;
                end
            end

            S_FIT:
            begin
                alu_op = ALU_SUB;
                alu_a  = CW'(h_real);
                alu_b  = CW'(size_reg);
                if (h_reg[FLAG_FREE_BIT] && !alu_borrow && (alu_res >= CW'(HDR)))
                begin
                    if (alu_res <= CW'(SLACK))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg[AW+1:2];
                        mem_wdata  = h_reg & ~HW'(1);
                        state_next = S_GRANT;
                    end
                    else
                    begin
                        diff_next  = alu_res;
                        state_next = S_SPLIT_A;
                    end
                end
                else if (h_reg[FLAG_LAST_BIT] || (h_real == '0))
                begin
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end

            S_ADV:
            begin
                alu_op = ALU_ADD;
                alu_a  = CW'(pos_reg);
                alu_b  = CW'(h_real);
                if ((n_inc == NW'(WORDS)) || (alu_res >= CW'(ARENA_BYTES)))
                begin
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    pos_next   = alu_res[HW-1:0];
                    n_next     = n_inc;
                    mem_raddr  = alu_res[AW+1:2];
                    state_next = S_HCHECK;
                end
            end

            S_SPLIT_A:
            begin
                alu_op     = ALU_ADD;
                alu_a      = CW'(pos_reg);
                alu_b      = CW'(size_reg);
                tmp_next   = alu_res;
                state_next = S_SPLIT_B;
            end

            S_SPLIT_B:
            begin
                // The remainder header starts right after the granted chunk.
                alu_op     = ALU_ADD;
                alu_a      = tmp_reg;
                alu_b      = CW'(HDR);
                tmp_next   = alu_res;
                state_next = S_SPLIT_C;
            end

            S_SPLIT_C:
            begin
                alu_op     = ALU_SUB;
                alu_a      = diff_reg;
                alu_b      = CW'(HDR);
                mem_we     = 1'b1;
                mem_waddr  = tmp_reg[AW+1:2];
                mem_wdata  = {alu_res[HW-1:2], h_reg[FLAG_LAST_BIT], h_reg[FLAG_FREE_BIT]};
                state_next = S_SPLIT_D;
            end

            S_SPLIT_D:
            begin
                alu_op     = ALU_ADD;
                alu_a      = CW'(size_reg);
                alu_b      = CW'(HDR);
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[AW+1:2];
                mem_wdata  = {alu_res[HW-1:2], 2'b00};
                state_next = S_GRANT;
            end

            S_GRANT:
            begin
                alu_op       = ALU_ADD;
                alu_a        = CW'(pos_reg);
                alu_b        = CW'(HDR);
                res_off_next = alu_res[OFF_W-1:0];
                res_ok_next  = 1'b1;
                state_next   = S_DONE;
            end

            S_FREE_A:
            begin
                alu_op = ALU_SUB;
                alu_a  = CW'(foff_reg);
                alu_b  = CW'(HDR);
                res_off_next = '0;
                if (alu_borrow || (alu_res[1:0] != 2'b00) ||
                    (alu_res >= CW'(ARENA_BYTES)))
                begin
                    res_ok_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next   = alu_res[HW-1:0];
                    mem_raddr  = alu_res[AW+1:2];
                    state_next = S_FREE_B;
                end
            end

            S_FREE_B:
            begin
                if (mem_rdata == '0)
                begin
                    res_ok_next = 1'b0;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = pos_reg[AW+1:2];
                    mem_wdata   = mem_rdata | HW'(1);
                    res_ok_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator over a fixed arena of ARENA_BYTES bytes, kept as a chain of
// chunk headers in an internal memory of ARENA_BYTES/4 words. After reset the block
// clears that memory and holds in_stall high meanwhile.
// A free request passes S_FREE_A and, unless its offset is rejected outright,
// S_FREE_B, before S_DONE loads the result register. An allocate request first
// rounds the size in S_SIZE. Each chunk it visits then passes S_HCHECK for the header
// check and S_FIT for the fit test. Stepping past a chunk adds S_ADV, and a free chunk
// adds S_ABS_CHK. A merge that stops on a follower it has read adds S_ABS_RD, and each
// chunk merged adds S_ABS_RD and S_ABS_CHK. The request ends with S_GRANT and S_DONE
// for a whole-chunk grant, S_SPLIT_A to S_SPLIT_D before those for a split, or S_DONE
// alone for a failure. The next request is accepted in the cycle after the result
// register is loaded. The pace is set by the single read port of the header memory and
// the one shared adder that every size and offset step passes through. One request is
// worked at a time. The result sits in an output register, so the next request is
// taken while it waits.
// Depends on ffha_pkg, ffha_mem, ffha_alu and ffha_seq.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [REQ_W-1:0]  req_size,
    input  logic [OFF_W-1:0]  free_offset,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OFF_W-1:0]  payload_offset,
    output logic              granted
);

    localparam int WORDS = ARENA_BYTES / 4;
    localparam int AW    = $clog2(WORDS);
    localparam int HW    = $clog2(ARENA_BYTES) + 1;
    localparam int CW    = ((HW > REQ_W + 1) ? HW : REQ_W + 1) + 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [HW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [HW-1:0] mem_rdata;
    alu_op_t       alu_op;
    logic [CW-1:0] alu_a;
    logic [CW-1:0] alu_b;
    logic [CW-1:0] alu_res;
    logic          alu_borrow;

    ffha_mem #(
        .WORDS (WORDS),
        .HW    (HW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffha_alu #(
        .W (CW)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    ffha_seq #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .WORDS        (WORDS),
        .HW           (HW),
        .CW           (CW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .req_size       (req_size),
        .free_offset    (free_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_offset (payload_offset),
        .granted        (granted),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .alu_op         (alu_op),
        .alu_a          (alu_a),
        .alu_b          (alu_b),
        .alu_res        (alu_res),
        .alu_borrow     (alu_borrow)
    );

endmodule
